@@ hdl/imh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package imh_pkg;
  localparam int CAPACITY     = 1024;
  localparam int HANDLE_COUNT = 1024;
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int HW = $clog2(HANDLE_COUNT + 1);

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_PEEK   = 3'd1;
  localparam logic [2:0] OP_DELMIN = 3'd2;
  localparam logic [2:0] OP_DELH   = 3'd3;
  localparam logic [2:0] OP_CHANGE = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BADH  = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic [10:0]        handle;
  } in_t;

  typedef struct packed {
    logic signed [31:0] min_value;
    logic [10:0]        new_handle;
    logic [1:0]         status;
  } out_t;
endpackage
`default_nettype wire

@@ hdl/indexed_min_heap.sv @@
`timescale 1ns / 1ps
`default_nettype none
// indexed binary min-heap of signed 32-bit values. start is taken when busy is
// low; busy stays high until the one result transaction, shown on out_data
// for a single cycle with out_valid; the receiver cannot stall it, so it must
// take it then. each memory has one port that reads or writes one word per
// cycle, so a sift going down reads the two children, compares and swaps
// (states SW0, SW1, SW2), and going up reads the parent, compares and swaps. a
// change or delete sifts down and then up. a clearing pass after reset
// empties the handle map, during which busy is high. handles are insertion
// numbers from 1; handle 0 and stale handles report a bad handle status.
module indexed_min_heap (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  output logic             busy,
  input  imh_pkg::in_t     in_data,
  output logic             out_valid,
  output imh_pkg::out_t    out_data
);
  localparam int PW = imh_pkg::PW;
  localparam int HW = imh_pkg::HW;

  // state codes
  localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE = 5'd1,  S_DEC   = 5'd2,
                         S_LK    = 5'd3,  S_LK2  = 5'd4,  S_RMA   = 5'd5,
                         S_RMB   = 5'd6,  S_RMC  = 5'd7,  S_DN0   = 5'd8,
                         S_DN1   = 5'd9,  S_DN2  = 5'd10, S_DN3   = 5'd11,
                         S_UP0   = 5'd12, S_UP1  = 5'd13, S_UP2   = 5'd14,
                         S_SW0   = 5'd15, S_SW1  = 5'd16, S_SW2   = 5'd17,
                         S_MIN   = 5'd18, S_MIN2 = 5'd19, S_DONE  = 5'd20,
                         S_RMD   = 5'd21;

  // memories, single port each, registered read
  logic signed [31:0] val_mem [1:imh_pkg::CAPACITY];
  logic [HW-1:0]      p2h_mem [1:imh_pkg::CAPACITY];
  logic [PW-1:0]      h2p_mem [0:imh_pkg::HANDLE_COUNT];

  logic               v_we, p_we, h_we;
  logic [PW-1:0]      v_a, p_a;
  logic [HW-1:0]      h_a;
  logic signed [31:0] v_wd, v_rd;
  logic [HW-1:0]      p_wd, p_rd;
  logic [PW-1:0]      h_wd, h_rd;

  always_ff @(posedge clk) begin
    if (v_we) val_mem[v_a] <= v_wd;
    v_rd <= val_mem[v_a];
  end
  always_ff @(posedge clk) begin
    if (p_we) p2h_mem[p_a] <= p_wd;
    p_rd <= p2h_mem[p_a];
  end
  always_ff @(posedge clk) begin
    if (h_we) h2p_mem[h_a] <= h_wd;
    h_rd <= h2p_mem[h_a];
  end

  logic [4:0]         st_r, st_nxt, ret_r, ret_nxt;
  imh_pkg::in_t       cmd_r, cmd_nxt;
  logic [PW-1:0]      size_r, size_nxt, p_r, p_nxt, q_r, q_nxt;
  logic [HW-1:0]      iss_r, iss_nxt, hp_r, hp_nxt, hq_r, hq_nxt;
  logic signed [31:0] vp_r, vp_nxt, vq_r, vq_nxt;
  logic               up_r, up_nxt; // sift up follows the current sift down
  logic               ov_r, ov_nxt;
  imh_pkg::out_t      od_r, od_nxt;
  logic [HW-1:0]      clr_r, clr_nxt;
  logic               sdone_r, sdone_nxt; // swap only writes the moved entry at p, with no exchange

  // left child index of p
  logic [PW:0] lch;
  assign lch = {p_r, 1'b0};

  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r; cmd_nxt = cmd_r; size_nxt = size_r;
    p_nxt = p_r; q_nxt = q_r; iss_nxt = iss_r; hp_nxt = hp_r; hq_nxt = hq_r;
    vp_nxt = vp_r; vq_nxt = vq_r; up_nxt = up_r; ov_nxt = 1'b0; od_nxt = od_r;
    clr_nxt = clr_r; sdone_nxt = sdone_r;
    v_we = 1'b0; p_we = 1'b0; h_we = 1'b0;
    v_a = p_r; p_a = p_r; h_a = hp_r;
    v_wd = vp_r; p_wd = hp_r; h_wd = p_r;
    unique case (st_r)
      S_CLEAR: begin
        h_we = 1'b1; h_a = clr_r; h_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == HW'(imh_pkg::HANDLE_COUNT)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_data;
          od_nxt = '0;
          st_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (cmd_r.operation)
          imh_pkg::OP_INSERT: begin
            if (size_r >= PW'(imh_pkg::CAPACITY) ||
                iss_r >= HW'(imh_pkg::HANDLE_COUNT)) begin
              od_nxt.status = imh_pkg::ST_FULL; st_nxt = S_MIN;
            end else begin
              size_nxt = size_r + 1'b1;
              iss_nxt = iss_r + 1'b1;
              p_nxt = size_r + 1'b1;
              v_we = 1'b1; v_a = size_r + 1'b1; v_wd = cmd_r.value;
              p_we = 1'b1; p_a = size_r + 1'b1; p_wd = iss_r + 1'b1;
              h_we = 1'b1; h_a = iss_r + 1'b1; h_wd = size_r + 1'b1;
              od_nxt.new_handle = 11'(iss_r + 1'b1);
              vp_nxt = cmd_r.value; hp_nxt = iss_r + 1'b1;
              up_nxt = 1'b0;
              st_nxt = S_UP0;
            end
          end
          imh_pkg::OP_DELMIN: begin
            if (size_r == '0) begin
              od_nxt.status = imh_pkg::ST_EMPTY; st_nxt = S_MIN;
            end else begin
              p_nxt = PW'(1); st_nxt = S_RMA;
            end
          end
          imh_pkg::OP_DELH, imh_pkg::OP_CHANGE: begin
            if (cmd_r.handle == '0 || cmd_r.handle > 11'(iss_r)) begin
              od_nxt.status = imh_pkg::ST_BADH; st_nxt = S_MIN;
            end else begin
              h_a = HW'(cmd_r.handle); st_nxt = S_LK;
            end
          end
          default: begin
            if (size_r == '0) od_nxt.status = imh_pkg::ST_EMPTY;
            st_nxt = S_MIN;
          end
        endcase
      end
      S_LK: begin
        h_a = HW'(cmd_r.handle);
        st_nxt = S_LK2;
      end
      S_LK2: begin
        if (h_rd == '0) begin
          od_nxt.status = imh_pkg::ST_BADH; st_nxt = S_MIN;
        end else begin
          p_nxt = h_rd;
          if (cmd_r.operation == imh_pkg::OP_CHANGE) begin
            v_we = 1'b1; v_a = h_rd; v_wd = cmd_r.value;
            vp_nxt = cmd_r.value;
            p_a = h_rd;
            st_nxt = S_RMD;
            up_nxt = 1'b1;
          end else st_nxt = S_RMA;
        end
      end
      S_RMD: begin
        // handle at the changed position
        hp_nxt = p_rd; st_nxt = S_DN0;
      end
      // remove at p: move last entry into p, drop handle of p
      S_RMA: begin
        v_a = size_r; p_a = size_r; st_nxt = S_RMB;
      end
      S_RMB: begin
        vq_nxt = v_rd; hq_nxt = p_rd;
        p_a = p_r; st_nxt = S_RMC;
      end
      S_RMC: begin
        // p_rd is handle at p, removed
        h_we = 1'b1; h_a = p_rd; h_wd = '0;
        size_nxt = size_r - 1'b1;
        if (p_r == size_r) st_nxt = S_MIN;
        else begin
          st_nxt = S_SW0; ret_nxt = S_DN0;
          vp_nxt = vq_r; hp_nxt = hq_r; up_nxt = 1'b1;
          sdone_nxt = 1'b1; // write moved entry at p then sift
        end
      end
      // sift down: p holds vp/hp; read children
      S_DN0: begin
        if (lch > {1'b0, size_r}) begin
          st_nxt = up_r ? S_UP0 : S_MIN;
        end else begin
          v_a = lch[PW-1:0]; p_a = lch[PW-1:0];
          q_nxt = lch[PW-1:0];
          st_nxt = S_DN1;
        end
      end
      S_DN1: begin
        vq_nxt = v_rd; hq_nxt = p_rd;
        if (lch + 1'b1 <= {1'b0, size_r}) begin
          v_a = PW'(lch + 1'b1); p_a = PW'(lch + 1'b1);
          st_nxt = S_DN2;
        end else st_nxt = S_DN3;
      end
      S_DN2: begin
        if (v_rd < vq_r) begin
          vq_nxt = v_rd; hq_nxt = p_rd; q_nxt = PW'(lch + 1'b1);
        end
        st_nxt = S_DN3;
      end
      S_DN3: begin
        if (vq_r < vp_r) begin
          st_nxt = S_SW0; ret_nxt = S_DN0;
        end else st_nxt = up_r ? S_UP0 : S_MIN;
      end
      // sift up
      S_UP0: begin
        if (p_r[PW-1:1] == '0) st_nxt = S_MIN;
        else begin
          v_a = p_r >> 1; p_a = p_r >> 1; q_nxt = p_r >> 1;
          st_nxt = S_UP1;
        end
      end
      S_UP1: begin
        vq_nxt = v_rd; hq_nxt = p_rd; st_nxt = S_UP2;
      end
      S_UP2: begin
        // parent value captured in vq
        if (vq_r > vp_r) begin
          st_nxt = S_SW0; ret_nxt = S_UP0;
        end else st_nxt = S_MIN;
      end
      // swap: q entry (vq/hq) goes to p, the moving entry goes to q
      S_SW0: begin
        if (sdone_r) begin
          // plain write of moved entry into p
          v_we = 1'b1; v_a = p_r; v_wd = vp_r;
          p_we = 1'b1; p_a = p_r; p_wd = hp_r;
          st_nxt = S_SW2;
        end else begin
          v_we = 1'b1; v_a = p_r; v_wd = vq_r;
          p_we = 1'b1; p_a = p_r; p_wd = hq_r;
          st_nxt = S_SW1;
        end
      end
      S_SW1: begin
        h_we = 1'b1; h_a = hq_r; h_wd = p_r;
        v_we = 1'b1; v_a = q_r; v_wd = vp_r;
        p_we = 1'b1; p_a = q_r; p_wd = hp_r;
        p_nxt = q_r;
        st_nxt = S_SW2;
      end
      S_SW2: begin
        h_we = 1'b1; h_a = hp_r; h_wd = p_r;
        sdone_nxt = 1'b0;
        st_nxt = ret_r;
      end
      S_MIN: begin
        v_a = PW'(1); st_nxt = S_MIN2;
      end
      S_MIN2: begin
        od_nxt.min_value = (size_r == '0) ? 32'sd0 : v_rd;
        ov_nxt = 1'b1;
        st_nxt = S_DONE;
      end
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; size_r <= '0; iss_r <= '0; ov_r <= 1'b0;
      clr_r <= '0; sdone_r <= 1'b0; up_r <= 1'b0; ret_r <= S_IDLE;
    end else begin
      st_r <= st_nxt; size_r <= size_nxt; iss_r <= iss_nxt; ov_r <= ov_nxt;
      clr_r <= clr_nxt; sdone_r <= sdone_nxt; up_r <= up_nxt; ret_r <= ret_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; p_r <= p_nxt; q_r <= q_nxt; vp_r <= vp_nxt;
    vq_r <= vq_nxt; hq_r <= hq_nxt; od_r <= od_nxt;
    hp_r <= hp_nxt;
  end

  assign busy      = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  a_size_cap: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= PW'(imh_pkg::CAPACITY)) else $error("heap size above capacity");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held two cycles");
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_issue_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_CLEAR) |=> iss_r >= $past(iss_r)) else $error("handle count fell");
endmodule
`default_nettype wire

@@ dv/imh_checker.sv @@
`timescale 1ns / 1ps
module imh_checker
  import imh_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   start,
  input  wire   busy,
  input  in_t   in_data,
  input  wire   out_valid,
  input  out_t  out_data,
  output int    fail_count,
  output int    pending
);
  // shadow copy of the heap
  logic signed [31:0] heap_val [1:CAPACITY];
  int                 pos_hnd  [1:CAPACITY];
  int                 hnd_pos  [0:HANDLE_COUNT];
  int                 heap_cnt;
  int                 issued_cnt;
  out_t               expected_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    heap_cnt   = 0;
    issued_cnt = 0;
    foreach (hnd_pos[i]) hnd_pos[i] = 0;
  end

  function void swap_slots(int a, int b);
    int ha, hb;
    logic signed [31:0] v;
    ha = pos_hnd[a];
    hb = pos_hnd[b];
    v  = heap_val[a];
    hnd_pos[ha] = b;
    hnd_pos[hb] = a;
    pos_hnd[a]  = hb;
    pos_hnd[b]  = ha;
    heap_val[a] = heap_val[b];
    heap_val[b] = v;
  endfunction

  function void push_down(int p);
    int best;
    forever begin
      best = p;
      if (2*p <= heap_cnt && heap_val[2*p] < heap_val[best]) best = 2*p;
      if (2*p+1 <= heap_cnt && heap_val[2*p+1] < heap_val[best]) best = 2*p+1;
      if (best == p) return;
      swap_slots(p, best);
      p = best;
    end
  endfunction

  function void push_up(int p);
    while (p/2 != 0 && heap_val[p/2] > heap_val[p]) begin
      swap_slots(p/2, p);
      p = p/2;
    end
  endfunction

  function void remove_slot(int p);
    int last;
    last = heap_cnt;
    swap_slots(p, last);
    hnd_pos[pos_hnd[last]] = 0;
    heap_cnt--;
    if (p <= heap_cnt) begin
      push_down(p);
      push_up(p);
    end
  endfunction

  function int find_slot(int h);
    if (h == 0 || h > issued_cnt) return 0;
    return hnd_pos[h];
  endfunction

  function out_t apply_op(in_t it);
    out_t r;
    int   p;
    r = '0;
    case (it.operation)
      OP_INSERT: begin
        if (heap_cnt >= CAPACITY || issued_cnt >= HANDLE_COUNT) begin
          r.status = ST_FULL;
        end else begin
          heap_cnt++;
          issued_cnt++;
          heap_val[heap_cnt] = it.value;
          pos_hnd[heap_cnt]  = issued_cnt;
          hnd_pos[issued_cnt] = heap_cnt;
          push_up(heap_cnt);
          r.new_handle = 11'(issued_cnt);
        end
      end
      OP_DELMIN: begin
        if (heap_cnt == 0) r.status = ST_EMPTY;
        else remove_slot(1);
      end
      OP_DELH: begin
        p = find_slot(it.handle);
        if (p == 0) r.status = ST_BADH;
        else remove_slot(p);
      end
      OP_CHANGE: begin
        p = find_slot(it.handle);
        if (p == 0) begin
          r.status = ST_BADH;
        end else begin
          heap_val[p] = it.value;
          push_down(p);
          push_up(p);
        end
      end
      // peek and the unused codes
      default: begin
        if (heap_cnt == 0) r.status = ST_EMPTY;
      end
    endcase
    r.min_value = (heap_cnt != 0) ? heap_val[1] : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n) begin
      if (start && !busy) expected_q.push_back(apply_op(in_data));
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transaction: %p", out_data);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r !== out_data) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected min %0d hnd %0d st %0d, got min %0d hnd %0d st %0d",
                       exp_r.min_value, exp_r.new_handle, exp_r.status,
                       out_data.min_value, out_data.new_handle, out_data.status);
          end
        end
      end
      pending <= expected_q.size();
    end
  end
endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import imh_pkg::*;

  // codes the block treats like a peek
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_data = '0;
  wire  busy;
  wire  out_valid;
  out_t out_data;
  int   fail_count;
  int   pending;
  int   inserts_sent = 0;
  int   sent_cnt = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  indexed_min_heap u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  imh_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // handles the block has handed out so far (an insert only fails once exhausted)
  function int handles_out();
    return (inserts_sent < HANDLE_COUNT) ? inserts_sent : HANDLE_COUNT;
  endfunction

  function logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3, 4: return $signed($urandom_range(0, 16)) - 8;  // lots of ties
      default: return $urandom;
    endcase
  endfunction

  function logic [10:0] pick_handle();
    int n;
    n = handles_out();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 11'($urandom_range(0, 2047));
      2: return 11'(n + 1);
      default: return (n == 0) ? 11'd1 : 11'($urandom_range(1, n));
    endcase
  endfunction

  // hold start until the block takes the transaction
  task automatic issue(logic [2:0] op, logic signed [31:0] val, logic [10:0] hnd);
    in_t it;
    it.operation = op;
    it.value     = val;
    it.handle    = hnd;
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    if (op == OP_INSERT) inserts_sent++;
    sent_cnt++;
  endtask

  // random gaps, none in the quiet window
  task automatic maybe_gap();
    if (!(sent_cnt > 400 && sent_cnt < 700) && $urandom_range(0, 99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35)      issue(OP_INSERT, pick_value(), 11'($urandom));
    else if (r < 45) issue(OP_PEEK, $urandom, 11'($urandom));
    else if (r < 60) issue(OP_DELMIN, $urandom, 11'($urandom));
    else if (r < 75) issue(OP_DELH, $urandom, pick_handle());
    else if (r < 95) issue(OP_CHANGE, pick_value(), pick_handle());
    else             issue(3'($urandom_range(5, 7)), $urandom, 11'($urandom));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty heap: every operation reports empty or bad handle
    issue(OP_PEEK, 0, 0);
    issue(OP_DELMIN, 0, 0);
    issue(OP_DELH, 0, 11'd1);
    issue(OP_CHANGE, 5, 11'd1);
    issue(OP_RSVD5, 0, 0);
    maybe_gap();
    // extremes and ties
    issue(OP_INSERT, 32'sh7fffffff, 0);
    issue(OP_INSERT, 32'sh80000000, 0);
    issue(OP_INSERT, 0, 0);
    issue(OP_INSERT, -1, 0);
    issue(OP_INSERT, 5, 0);
    issue(OP_INSERT, 5, 0);
    issue(OP_PEEK, 0, 0);
    issue(OP_CHANGE, 32'sh80000000, 11'd3);
    issue(OP_CHANGE, 32'sh7fffffff, 11'd2);
    // handle 6 is not in the last slot: the last entry moves into its slot
    issue(OP_DELH, 0, 11'd6);
    issue(OP_DELH, 0, 11'd1);
    issue(OP_DELH, 0, 11'd1);       // stale handle
    issue(OP_CHANGE, 1, 11'd0);
    issue(OP_CHANGE, 1, 11'd2047);  // beyond anything issued
    issue(OP_RSVD6, -1, 11'h7ff);
    issue(OP_RSVD7, 0, 0);
    issue(OP_DELMIN, 0, 0);
    issue(OP_DELMIN, 0, 0);
    issue(OP_DELMIN, 0, 0);

    repeat (400) begin
      maybe_gap();
      random_op();
    end

    // use up every handle, then hit the exhausted case
    while (inserts_sent < HANDLE_COUNT + 3) begin
      maybe_gap();
      if ($urandom_range(0, 7) == 0) random_op();
      else issue(OP_INSERT, pick_value(), 0);
    end
    repeat (30) begin
      maybe_gap();
      issue(OP_DELMIN, 0, 0);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("indexed_min_heap regression: pass");
    end else begin
      $display("indexed_min_heap regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("indexed_min_heap regression: fail");
    $finish;
  end
endmodule

@@ sim.f @@
hdl/imh_pkg.sv
hdl/indexed_min_heap.sv
dv/imh_checker.sv
dv/testbench.sv
